>>> rtl/assert_macros.svh
// Assertion helpers for the linked list manager.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define LLM_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define LLM_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/llm_pkg.sv
package llm_pkg;

    localparam int PW = 7;
    localparam int LISTS = 3;
    localparam int LW = 2;
    localparam logic [PW-1:0] NIL = 7'd127;

    typedef enum logic [3:0] {
        CMD_INS_IDX    = 4'd0,
        CMD_INS_BEFORE = 4'd1,
        CMD_INS_AFTER  = 4'd2,
        CMD_DEL_IDX    = 4'd3,
        CMD_DEL_BEFORE = 4'd4,
        CMD_DEL_AFTER  = 4'd5,
        CMD_DEL_VAL    = 4'd6,
        CMD_READ       = 4'd7,
        CMD_FIND       = 4'd8,
        CMD_CLEAR      = 4'd9,
        CMD_CAT2       = 4'd10,
        CMD_CAT3       = 4'd11,
        CMD_DUMP       = 4'd12
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_RANGE     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_NO_NBR    = 3'd4,
        ST_BAD_OCC   = 3'd5,
        ST_POOL_FULL = 3'd6,
        ST_BAD_LIST  = 3'd7
    } t_status;

    typedef enum logic [2:0] {
        VS_ZERO,
        VS_NVAL,
        VS_KEY,
        VS_RDV,
        VS_RVAL
    } t_vsel;

    typedef enum logic [1:0] {
        PS_ZERO,
        PS_TGT,
        PS_IDX
    } t_psel;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_INIT,
        OP_SRCH_STEP,
        OP_SET_TGT,
        OP_SCAN_STEP,
        OP_LOC_INIT,
        OP_LOC_STEP,
        OP_VIC_CAP,
        OP_STEP,
        OP_CLR_STEP,
        OP_CLR_FIN,
        OP_INS1,
        OP_INS2,
        OP_DEL,
        OP_JOIN_B,
        OP_JOIN_C
    } t_op;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_SRCH_A,
        S_SRCH_B,
        S_SRCH_END,
        S_DISP,
        S_SCAN,
        S_LOC,
        S_LOC_A,
        S_LOC_B,
        S_VIC_A,
        S_VIC_B,
        S_DEL,
        S_EMIT_DEL,
        S_INS1,
        S_INS2,
        S_CLR_A,
        S_CLR_B,
        S_CLR_FIN,
        S_JOIN1,
        S_JOIN2,
        S_EMIT_OK0,
        S_DUMP_A,
        S_DUMP_B
    } t_state;

    typedef struct packed {
        t_op     op;
        logic    emit;
        t_status st;
        t_vsel   vsel;
        t_psel   psel;
        logic    last;
    } t_ctrl;

    typedef struct packed {
        logic [3:0] cmd;
        logic       ls_bad;
        logic       cat_bad;
        logic       cat_empty;
        logic       len_zero;
        logic       pos_bad;
        logic       walk_end;
        logic       loc_end;
        logic       tgt_le1;
        logic       match_none;
        logic       match_bad;
        logic       no_nbr;
        logic       used_cur;
        logic       scan_end;
    } t_stat;

endpackage

>>> rtl/llm_ctrl.sv
module llm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  llm_pkg::t_stat i_stat,
    output llm_pkg::t_ctrl o_ctrl,
    output logic           o_busy
);

    llm_pkg::t_state r_state;
    llm_pkg::t_state n_state;
    logic            is_ins;

    assign is_ins = i_stat.cmd inside {llm_pkg::CMD_INS_IDX, llm_pkg::CMD_INS_BEFORE,
                                       llm_pkg::CMD_INS_AFTER};
    assign o_busy = (r_state != llm_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= llm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_ctrl.op   = llm_pkg::OP_NONE;
        o_ctrl.emit = 1'b0;
        o_ctrl.st   = llm_pkg::ST_OK;
        o_ctrl.vsel = llm_pkg::VS_ZERO;
        o_ctrl.psel = llm_pkg::PS_ZERO;
        o_ctrl.last = 1'b1;
        case (r_state)
            llm_pkg::S_IDLE: begin
                if (i_start) begin
                    o_ctrl.op = llm_pkg::OP_LOAD;
                    n_state   = llm_pkg::S_CHECK;
                end
            end
            llm_pkg::S_CHECK: begin
                o_ctrl.op = llm_pkg::OP_INIT;
                n_state   = llm_pkg::S_IDLE;
                if (i_stat.cmd > llm_pkg::CMD_DUMP) begin
                    n_state = llm_pkg::S_IDLE;
                end else if (i_stat.ls_bad) begin
                    o_ctrl.emit = 1'b1;
                    o_ctrl.st   = llm_pkg::ST_BAD_LIST;
                end else if (i_stat.cmd inside {llm_pkg::CMD_CAT2, llm_pkg::CMD_CAT3}) begin
                    if (i_stat.cat_bad) begin
                        o_ctrl.emit = 1'b1;
                        o_ctrl.st   = llm_pkg::ST_BAD_LIST;
                    end else if (i_stat.cat_empty) begin
                        o_ctrl.emit = 1'b1;
                        o_ctrl.st   = llm_pkg::ST_EMPTY;
                    end else begin
                        n_state = llm_pkg::S_JOIN1;
                    end
                end else if (i_stat.cmd == llm_pkg::CMD_INS_IDX) begin
                    if (i_stat.pos_bad) begin
                        o_ctrl.emit = 1'b1;
                        o_ctrl.st   = llm_pkg::ST_RANGE;
                    end else begin
                        n_state = llm_pkg::S_SCAN;
                    end
                end else if (i_stat.len_zero) begin
                    o_ctrl.emit = 1'b1;
                    o_ctrl.st   = llm_pkg::ST_EMPTY;
                end else if (i_stat.cmd inside {llm_pkg::CMD_INS_BEFORE,
                                                llm_pkg::CMD_INS_AFTER,
                                                llm_pkg::CMD_DEL_BEFORE,
                                                llm_pkg::CMD_DEL_AFTER,
                                                llm_pkg::CMD_DEL_VAL,
                                                llm_pkg::CMD_FIND}) begin
                    n_state = llm_pkg::S_SRCH_A;
                end else if (i_stat.cmd inside {llm_pkg::CMD_DEL_IDX,
                                                llm_pkg::CMD_READ}) begin
                    if (i_stat.pos_bad) begin
                        o_ctrl.emit = 1'b1;
                        o_ctrl.st   = llm_pkg::ST_RANGE;
                    end else begin
                        n_state = llm_pkg::S_LOC;
                    end
                end else if (i_stat.cmd == llm_pkg::CMD_CLEAR) begin
                    n_state = llm_pkg::S_CLR_A;
                end else begin
                    n_state = llm_pkg::S_DUMP_A;
                end
            end
            llm_pkg::S_SRCH_A: begin
                n_state = llm_pkg::S_SRCH_B;
            end
            llm_pkg::S_SRCH_B: begin
                o_ctrl.op = llm_pkg::OP_SRCH_STEP;
                n_state   = i_stat.walk_end ? llm_pkg::S_SRCH_END : llm_pkg::S_SRCH_A;
            end
            llm_pkg::S_SRCH_END: begin
                n_state = llm_pkg::S_IDLE;
                if (i_stat.match_none) begin
                    o_ctrl.emit = 1'b1;
                    o_ctrl.st   = llm_pkg::ST_NOT_FOUND;
                end else if (i_stat.match_bad) begin
                    o_ctrl.emit = 1'b1;
                    o_ctrl.st   = llm_pkg::ST_BAD_OCC;
                end else begin
                    o_ctrl.op = llm_pkg::OP_SET_TGT;
                    n_state   = llm_pkg::S_DISP;
                end
            end
            llm_pkg::S_DISP: begin
                n_state = llm_pkg::S_IDLE;
                if (i_stat.cmd == llm_pkg::CMD_FIND) begin
                    o_ctrl.emit = 1'b1;
                    o_ctrl.vsel = llm_pkg::VS_KEY;
                    o_ctrl.psel = llm_pkg::PS_TGT;
                end else if (i_stat.no_nbr) begin
                    o_ctrl.emit = 1'b1;
                    o_ctrl.st   = llm_pkg::ST_NO_NBR;
                end else if (is_ins) begin
                    n_state = llm_pkg::S_SCAN;
                end else begin
                    n_state = llm_pkg::S_LOC;
                end
            end
            llm_pkg::S_SCAN: begin
                if (!i_stat.used_cur) begin
                    n_state = llm_pkg::S_LOC;
                end else if (i_stat.scan_end) begin
                    o_ctrl.emit = 1'b1;
                    o_ctrl.st   = llm_pkg::ST_POOL_FULL;
                    n_state     = llm_pkg::S_IDLE;
                end else begin
                    o_ctrl.op = llm_pkg::OP_SCAN_STEP;
                end
            end
            llm_pkg::S_LOC: begin
                o_ctrl.op = llm_pkg::OP_LOC_INIT;
                if (!i_stat.tgt_le1) begin
                    n_state = llm_pkg::S_LOC_A;
                end else begin
                    n_state = is_ins ? llm_pkg::S_INS1 : llm_pkg::S_VIC_A;
                end
            end
            llm_pkg::S_LOC_A: begin
                n_state = llm_pkg::S_LOC_B;
            end
            llm_pkg::S_LOC_B: begin
                o_ctrl.op = llm_pkg::OP_LOC_STEP;
                if (!i_stat.loc_end) begin
                    n_state = llm_pkg::S_LOC_A;
                end else begin
                    n_state = is_ins ? llm_pkg::S_INS1 : llm_pkg::S_VIC_A;
                end
            end
            llm_pkg::S_VIC_A: begin
                n_state = llm_pkg::S_VIC_B;
            end
            llm_pkg::S_VIC_B: begin
                if (i_stat.cmd == llm_pkg::CMD_READ) begin
                    o_ctrl.emit = 1'b1;
                    o_ctrl.vsel = llm_pkg::VS_RDV;
                    o_ctrl.psel = llm_pkg::PS_TGT;
                    n_state     = llm_pkg::S_IDLE;
                end else begin
                    o_ctrl.op = llm_pkg::OP_VIC_CAP;
                    n_state   = llm_pkg::S_DEL;
                end
            end
            llm_pkg::S_DEL: begin
                o_ctrl.op = llm_pkg::OP_DEL;
                n_state   = llm_pkg::S_EMIT_DEL;
            end
            llm_pkg::S_EMIT_DEL: begin
                o_ctrl.emit = 1'b1;
                o_ctrl.vsel = llm_pkg::VS_RVAL;
                o_ctrl.psel = llm_pkg::PS_TGT;
                n_state     = llm_pkg::S_IDLE;
            end
            llm_pkg::S_INS1: begin
                o_ctrl.op = llm_pkg::OP_INS1;
                n_state   = llm_pkg::S_INS2;
            end
            llm_pkg::S_INS2: begin
                o_ctrl.op   = llm_pkg::OP_INS2;
                o_ctrl.emit = 1'b1;
                o_ctrl.vsel = llm_pkg::VS_NVAL;
                o_ctrl.psel = llm_pkg::PS_TGT;
                n_state     = llm_pkg::S_IDLE;
            end
            llm_pkg::S_CLR_A: begin
                n_state = llm_pkg::S_CLR_B;
            end
            llm_pkg::S_CLR_B: begin
                o_ctrl.op = llm_pkg::OP_CLR_STEP;
                n_state   = i_stat.walk_end ? llm_pkg::S_CLR_FIN : llm_pkg::S_CLR_A;
            end
            llm_pkg::S_CLR_FIN: begin
                o_ctrl.op = llm_pkg::OP_CLR_FIN;
                n_state   = llm_pkg::S_EMIT_OK0;
            end
            llm_pkg::S_JOIN1: begin
                o_ctrl.op = llm_pkg::OP_JOIN_B;
                n_state   = (i_stat.cmd == llm_pkg::CMD_CAT3) ? llm_pkg::S_JOIN2
                                                              : llm_pkg::S_EMIT_OK0;
            end
            llm_pkg::S_JOIN2: begin
                o_ctrl.op = llm_pkg::OP_JOIN_C;
                n_state   = llm_pkg::S_EMIT_OK0;
            end
            llm_pkg::S_EMIT_OK0: begin
                o_ctrl.emit = 1'b1;
                n_state     = llm_pkg::S_IDLE;
            end
            llm_pkg::S_DUMP_A: begin
                n_state = llm_pkg::S_DUMP_B;
            end
            llm_pkg::S_DUMP_B: begin
                o_ctrl.op   = llm_pkg::OP_STEP;
                o_ctrl.emit = 1'b1;
                o_ctrl.vsel = llm_pkg::VS_RDV;
                o_ctrl.psel = llm_pkg::PS_IDX;
                o_ctrl.last = i_stat.walk_end;
                n_state     = i_stat.walk_end ? llm_pkg::S_IDLE : llm_pkg::S_DUMP_A;
            end
            default: begin
                n_state = llm_pkg::S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/llm_dp.sv
module llm_dp #(
    parameter int NODES = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  llm_pkg::t_ctrl                i_ctrl,
    input  logic [3:0]                    i_cmd,
    input  logic [1:0]                    i_list_sel,
    input  logic [1:0]                    i_list_b,
    input  logic [1:0]                    i_list_c,
    input  logic [6:0]                    i_position,
    input  logic signed [31:0]            i_key_value,
    input  logic signed [31:0]            i_new_value,
    input  logic [6:0]                    i_occurrence,
    output llm_pkg::t_stat                o_stat,
    output logic                          o_valid,
    output logic [2:0]                    o_status,
    output logic signed [31:0]            o_value,
    output logic [6:0]                    o_position_res,
    output logic [6:0]                    o_length,
    output logic                          o_last
);

    localparam int IW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int PW = llm_pkg::PW;

    logic [3:0]              r_cmd;
    logic [1:0]              r_ls;
    logic [1:0]              r_lb;
    logic [1:0]              r_lc;
    logic [6:0]              r_pos;
    logic signed [31:0]      r_key;
    logic signed [31:0]      r_nval;
    logic [6:0]              r_occ;

    logic [PW-1:0]           r_head [llm_pkg::LISTS];
    logic [PW-1:0]           r_tail [llm_pkg::LISTS];
    logic [6:0]              r_len  [llm_pkg::LISTS];
    logic [NODES-1:0]        r_used;

    logic signed [31:0]      r_mem_value [NODES];
    logic [PW-1:0]           r_mem_link  [NODES];
    logic signed [31:0]      r_rd_value;
    logic [PW-1:0]           r_rd_link;

    logic [PW-1:0]           r_cur;
    logic [PW-1:0]           r_prev;
    logic [PW-1:0]           r_plink;
    logic [PW-1:0]           r_vlink;
    logic [6:0]              r_idx;
    logic [6:0]              r_cnt;
    logic [6:0]              r_first;
    logic [6:0]              r_pick;
    logic [6:0]              r_tgt;
    logic signed [31:0]      r_val;
    logic [IW-1:0]           r_scan;

    logic                    ls_ok;
    logic                    lb_ok;
    logic                    lc_ok;
    logic                    cat3;
    logic [PW-1:0]           head_ls;
    logic [PW-1:0]           tail_ls;
    logic [6:0]              len_ls;
    logic [6:0]              len_b;
    logic [6:0]              len_c;
    logic [1:0]              src;
    logic [PW-1:0]           f_ptr;
    logic [6:0]              cnt_n;
    logic [6:0]              where;
    logic [6:0]              tgt_n;
    logic                    link_we;
    logic [IW-1:0]           link_waddr;
    logic [PW-1:0]           link_wdata;
    logic signed [31:0]      val_sel;
    logic [6:0]              pos_sel;

    assign ls_ok   = (r_ls < 2'(llm_pkg::LISTS));
    assign lb_ok   = (r_lb < 2'(llm_pkg::LISTS));
    assign lc_ok   = (r_lc < 2'(llm_pkg::LISTS));
    assign cat3    = (r_cmd == llm_pkg::CMD_CAT3);
    assign head_ls = ls_ok ? r_head[r_ls] : llm_pkg::NIL;
    assign tail_ls = ls_ok ? r_tail[r_ls] : llm_pkg::NIL;
    assign len_ls  = ls_ok ? r_len[r_ls] : 7'd0;
    assign len_b   = lb_ok ? r_len[r_lb] : 7'd0;
    assign len_c   = lc_ok ? r_len[r_lc] : 7'd0;
    assign src     = (i_ctrl.op == llm_pkg::OP_JOIN_C) ? r_lc : r_lb;
    assign f_ptr   = PW'(r_scan);
    assign cnt_n   = r_cnt + 7'd1;
    assign where   = (r_cnt == 7'd1) ? r_first : r_pick;

    always_comb begin
        case (r_cmd)
            llm_pkg::CMD_INS_AFTER,
            llm_pkg::CMD_DEL_AFTER:  tgt_n = where + 7'd1;
            llm_pkg::CMD_DEL_BEFORE: tgt_n = where - 7'd1;
            default:                 tgt_n = where;
        endcase
    end

    always_comb begin
        o_stat.cmd        = r_cmd;
        o_stat.ls_bad     = !ls_ok;
        o_stat.cat_bad    = !lb_ok || (r_lb == r_ls) ||
                            (cat3 && (!lc_ok || (r_lc == r_ls) || (r_lc == r_lb)));
        o_stat.cat_empty  = (len_ls == 7'd0) || (len_b == 7'd0) ||
                            (cat3 && (len_c == 7'd0));
        o_stat.len_zero   = (len_ls == 7'd0);
        if (r_cmd == llm_pkg::CMD_INS_IDX) begin
            o_stat.pos_bad = (r_pos == 7'd0) ||
                             ({1'b0, r_pos} > ({1'b0, len_ls} + 8'd1));
        end else begin
            o_stat.pos_bad = (r_pos == 7'd0) || (r_pos > len_ls);
        end
        o_stat.walk_end   = (r_idx == len_ls);
        o_stat.loc_end    = (r_idx == (r_tgt - 7'd1));
        o_stat.tgt_le1    = (r_tgt <= 7'd1);
        o_stat.match_none = (r_cnt == 7'd0);
        o_stat.match_bad  = (r_cnt > 7'd1) && ((r_occ == 7'd0) || (r_occ > r_cnt));
        o_stat.no_nbr     = ((r_cmd == llm_pkg::CMD_DEL_BEFORE) && (r_tgt == 7'd0)) ||
                            ((r_cmd == llm_pkg::CMD_DEL_AFTER) &&
                             ({1'b0, r_tgt} == ({1'b0, len_ls} + 8'd1)));
        o_stat.used_cur   = r_used[r_scan];
        o_stat.scan_end   = (r_scan == IW'(NODES - 1));
    end

    always_comb begin
        link_we    = 1'b0;
        link_waddr = r_scan;
        link_wdata = r_plink;
        case (i_ctrl.op)
            llm_pkg::OP_INS1: begin
                link_we = 1'b1;
            end
            llm_pkg::OP_INS2: begin
                link_we    = (r_prev != llm_pkg::NIL);
                link_waddr = r_prev[IW-1:0];
                link_wdata = f_ptr;
            end
            llm_pkg::OP_DEL: begin
                link_we    = (r_prev != llm_pkg::NIL);
                link_waddr = r_prev[IW-1:0];
                link_wdata = r_vlink;
            end
            llm_pkg::OP_JOIN_B,
            llm_pkg::OP_JOIN_C: begin
                link_we    = 1'b1;
                link_waddr = tail_ls[IW-1:0];
                link_wdata = r_head[src];
            end
            default: begin
                link_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rd_value <= r_mem_value[r_cur[IW-1:0]];
        r_rd_link  <= r_mem_link[r_cur[IW-1:0]];
        if (i_ctrl.op == llm_pkg::OP_INS1) begin
            r_mem_value[r_scan] <= r_nval;
        end
        if (link_we) begin
            r_mem_link[link_waddr] <= link_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_ctrl.op)
            llm_pkg::OP_LOAD: begin
                r_cmd  <= i_cmd;
                r_ls   <= i_list_sel;
                r_lb   <= i_list_b;
                r_lc   <= i_list_c;
                r_pos  <= i_position;
                r_key  <= i_key_value;
                r_nval <= i_new_value;
                r_occ  <= i_occurrence;
            end
            llm_pkg::OP_INIT: begin
                r_tgt  <= r_pos;
                r_scan <= '0;
                r_cur  <= head_ls;
                r_idx  <= 7'd1;
                r_cnt  <= 7'd0;
            end
            llm_pkg::OP_SRCH_STEP: begin
                if (r_rd_value == r_key) begin
                    r_cnt <= cnt_n;
                    if (cnt_n == 7'd1) begin
                        r_first <= r_idx;
                    end
                    if (cnt_n == r_occ) begin
                        r_pick <= r_idx;
                    end
                end
                r_cur <= r_rd_link;
                r_idx <= r_idx + 7'd1;
            end
            llm_pkg::OP_SET_TGT: begin
                r_tgt <= tgt_n;
            end
            llm_pkg::OP_SCAN_STEP: begin
                r_scan <= r_scan + IW'(1);
            end
            llm_pkg::OP_LOC_INIT: begin
                r_cur   <= head_ls;
                r_idx   <= 7'd1;
                r_prev  <= llm_pkg::NIL;
                r_plink <= head_ls;
            end
            llm_pkg::OP_LOC_STEP: begin
                r_prev  <= r_cur;
                r_plink <= r_rd_link;
                r_cur   <= r_rd_link;
                r_idx   <= r_idx + 7'd1;
            end
            llm_pkg::OP_VIC_CAP: begin
                r_val   <= r_rd_value;
                r_vlink <= r_rd_link;
            end
            llm_pkg::OP_STEP,
            llm_pkg::OP_CLR_STEP: begin
                r_cur <= r_rd_link;
                r_idx <= r_idx + 7'd1;
            end
            default: begin
                r_cur <= r_cur;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < llm_pkg::LISTS; i++) begin
                r_head[i] <= llm_pkg::NIL;
                r_tail[i] <= llm_pkg::NIL;
                r_len[i]  <= 7'd0;
            end
            r_used  <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_ctrl.emit;
            case (i_ctrl.op)
                llm_pkg::OP_INS1: begin
                    r_used[r_scan] <= 1'b1;
                    if (r_prev == llm_pkg::NIL) begin
                        r_head[r_ls] <= f_ptr;
                    end
                    if ({1'b0, r_tgt} == ({1'b0, len_ls} + 8'd1)) begin
                        r_tail[r_ls] <= f_ptr;
                    end
                    r_len[r_ls] <= len_ls + 7'd1;
                end
                llm_pkg::OP_DEL: begin
                    r_used[r_cur[IW-1:0]] <= 1'b0;
                    if (r_prev == llm_pkg::NIL) begin
                        r_head[r_ls] <= r_vlink;
                    end
                    if (r_tgt == len_ls) begin
                        r_tail[r_ls] <= r_prev;
                    end
                    r_len[r_ls] <= len_ls - 7'd1;
                    if (len_ls == 7'd1) begin
                        r_head[r_ls] <= llm_pkg::NIL;
                        r_tail[r_ls] <= llm_pkg::NIL;
                    end
                end
                llm_pkg::OP_CLR_STEP: begin
                    r_used[r_cur[IW-1:0]] <= 1'b0;
                end
                llm_pkg::OP_CLR_FIN: begin
                    r_head[r_ls] <= llm_pkg::NIL;
                    r_tail[r_ls] <= llm_pkg::NIL;
                    r_len[r_ls]  <= 7'd0;
                end
                llm_pkg::OP_JOIN_B,
                llm_pkg::OP_JOIN_C: begin
                    r_tail[r_ls] <= r_tail[src];
                    r_len[r_ls]  <= len_ls + r_len[src];
                    r_head[src]  <= llm_pkg::NIL;
                    r_tail[src]  <= llm_pkg::NIL;
                    r_len[src]   <= 7'd0;
                end
                default: begin
                    r_used <= r_used;
                end
            endcase
        end
    end

    always_comb begin
        case (i_ctrl.vsel)
            llm_pkg::VS_NVAL: val_sel = r_nval;
            llm_pkg::VS_KEY:  val_sel = r_key;
            llm_pkg::VS_RDV:  val_sel = r_rd_value;
            llm_pkg::VS_RVAL: val_sel = r_val;
            default:          val_sel = 32'sd0;
        endcase
        case (i_ctrl.psel)
            llm_pkg::PS_TGT: pos_sel = r_tgt;
            llm_pkg::PS_IDX: pos_sel = r_idx;
            default:         pos_sel = 7'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.emit) begin
            o_status       <= i_ctrl.st;
            o_value        <= val_sel;
            o_position_res <= pos_sel;
            o_length       <= len_ls;
            o_last         <= i_ctrl.last;
        end
    end

endmodule

>>> rtl/linked_list_manager.sv
// Three singly linked lists of signed words share one pool of NODES nodes. An item is
// taken when start is high and busy is low; busy stays high until its last result is
// shown. Results appear for one cycle each under o_valid and cannot be held off.
// Every command but dump and unknown codes gives one result; dump gives one per element,
// with o_last on the final one. Each node visit waits on the single registered read
// port of the node memory, and a free-node scan costs one cycle per node: a value-based
// insert or delete walks the whole list to find the match and then walks again to the
// target, and every insert first scans the pool for a free node. Unknown commands give
// no result.
`include "assert_macros.svh"

module linked_list_manager #(
    parameter int NODES = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [3:0]         i_cmd,
    input  logic [1:0]         i_list_sel,
    input  logic [1:0]         i_list_b,
    input  logic [1:0]         i_list_c,
    input  logic [6:0]         i_position,
    input  logic signed [31:0] i_key_value,
    input  logic signed [31:0] i_new_value,
    input  logic [6:0]         i_occurrence,
    output logic               o_valid,
    output logic [2:0]         o_status,
    output logic signed [31:0] o_value,
    output logic [6:0]         o_position_res,
    output logic [6:0]         o_length,
    output logic               o_last
);

    llm_pkg::t_ctrl ctrl;
    llm_pkg::t_stat stat;

    llm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_ctrl  (ctrl),
        .o_busy  (busy)
    );

    llm_dp #(
        .NODES (NODES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (ctrl),
        .i_cmd          (i_cmd),
        .i_list_sel     (i_list_sel),
        .i_list_b       (i_list_b),
        .i_list_c       (i_list_c),
        .i_position     (i_position),
        .i_key_value    (i_key_value),
        .i_new_value    (i_new_value),
        .i_occurrence   (i_occurrence),
        .o_stat         (stat),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_value        (o_value),
        .o_position_res (o_position_res),
        .o_length       (o_length),
        .o_last         (o_last)
    );

    `LLM_ASSERT_IMP(a_final_idle, o_valid && o_last, !busy, "final result while busy")
    `LLM_ASSERT_IMP(a_more_busy, o_valid && !o_last, busy, "partial result while idle")
    `LLM_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
    `LLM_ASSERT_IMP(a_err_zero, o_valid && (o_status != llm_pkg::ST_OK),
                    (o_value == 32'sd0) && (o_position_res == 7'd0),
                    "error result carries data")

endmodule
